@@ src/cmdfr_pkg.sv @@
package cmdfr_pkg;

  // opcode space covered by the framer
  localparam int unsigned OPCODE_COUNT = 71;
  localparam int unsigned TABLE_SIZE   = 71;
  localparam logic [7:0]  OPCODE_LIMIT = 8'(OPCODE_COUNT);

  // opcodes and argument codes with special handling
  localparam logic [6:0] OP_REDIRECT  = 7'h07;
  localparam logic [6:0] OP_CLEAR     = 7'h0C;
  localparam logic [6:0] OP_LOCATE    = 7'h24;
  localparam logic [7:0] CLEAR_ARG    = 8'hB0;
  localparam logic [7:0] REDIRECT_MIN = 8'h04;
  localparam logic [7:0] PRINT_LOW    = 8'h20;

  // result event codes
  typedef enum logic [1:0] {
    KIND_ABSORB = 2'd0,
    KIND_PRINT  = 2'd1,
    KIND_DROP   = 2'd2,
    KIND_DONE   = 2'd3
  } cmdfr_kind_e;

  // send lengths; bit 7 marks a zero-terminated variable frame
  localparam logic [7:0] SEND_TAB [TABLE_SIZE] = '{
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd3, 8'd4, 8'd3,
    8'd1, 8'd2, 8'd9, 8'd1, 8'd9, 8'd1, 8'd1, 8'd2,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd5, 8'd4, 8'h82, 8'd2,
    8'd1, 8'd1, 8'd10, 8'd2, 8'd1, 8'h81, 8'h81, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd4, 8'd1, 8'd1, 8'd3,
    8'd2, 8'd1, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'h82, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd9, 8'd1, 8'd3, 8'd3, 8'd1, 8'd1
  };

  // response lengths
  localparam logic [7:0] RESP_TAB [TABLE_SIZE] = '{
    8'd0, 8'd8, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd120,
    8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h80,
    8'd0, 8'd0, 8'd0, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'h80, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1,
    8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd8, 8'd1,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd8, 8'd2, 8'd2, 8'd1, 8'd1
  };

  // opcodes past the table send one byte and expect no response
  function automatic logic [7:0] send_len(input logic [6:0] op);
    logic [7:0] len;
    len = 8'd1;
    if (int'(op) < TABLE_SIZE) begin
      len = SEND_TAB[op];
    end
    return len;
  endfunction

  function automatic logic [7:0] resp_len(input logic [6:0] op);
    logic [7:0] len;
    len = 8'd0;
    if (int'(op) < TABLE_SIZE) begin
      len = RESP_TAB[op];
    end
    return len;
  endfunction

  // framer state, all cleared by reset
  typedef struct packed {
    logic [7:0] frame_count;
    logic [7:0] send_length;
    logic [6:0] current_opcode;
    logic [7:0] expected_response;
    logic       print_mode;
    logic [7:0] last_locate_x;
    logic [7:0] last_locate_y;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
  } cmdfr_state_t;

  // one result beat
  typedef struct packed {
    cmdfr_kind_e event_kind;
    logic [7:0]  byte_value;
    logic [7:0]  byte_index;
    logic [6:0]  opcode;
    logic [7:0]  response_length;
    logic        redirected;
    logic        clear_screen;
    logic        locate_mode;
    logic        show_char;
    logic [7:0]  cursor_x;
    logic [7:0]  cursor_y;
  } cmdfr_result_t;

endpackage

@@ src/cmdfr_if.sv @@
// host byte channel
interface cmdfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// framing result channel
interface cmdfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] byte_value;
  logic [7:0] byte_index;
  logic [6:0] opcode;
  logic [7:0] response_length;
  logic       redirected;
  logic       clear_screen;
  logic       locate_mode;
  logic       show_char;
  logic [7:0] cursor_x;
  logic [7:0] cursor_y;

  modport source (
    output valid, input ready,
    output event_kind, output byte_value, output byte_index, output opcode,
    output response_length, output redirected, output clear_screen,
    output locate_mode, output show_char, output cursor_x, output cursor_y
  );
  modport sink (
    input valid, output ready,
    input event_kind, input byte_value, input byte_index, input opcode,
    input response_length, input redirected, input clear_screen,
    input locate_mode, input show_char, input cursor_x, input cursor_y
  );
endinterface

@@ src/cmdfr_decode.sv @@
module cmdfr_decode
  import cmdfr_pkg::*;
(
  input  cmdfr_state_t  state_i,
  input  logic [7:0]    arg_one_i,
  input  logic [7:0]    arg_two_i,
  input  logic [7:0]    byte_i,
  output cmdfr_state_t  state_o,
  output logic [7:0]    arg_one_o,
  output logic [7:0]    arg_two_o,
  output cmdfr_result_t result_o
);

  logic [6:0] lead_op;
  logic [7:0] count_inc;
  logic       in_frame;

  assign lead_op   = byte_i[6:0];
  assign count_inc = state_i.frame_count + 8'd1;

  always_comb begin
    state_o   = state_i;
    arg_one_o = arg_one_i;
    arg_two_o = arg_two_i;
    in_frame  = 1'b0;

    result_o                 = '0;
    result_o.event_kind      = KIND_ABSORB;
    result_o.byte_value      = byte_i;

    if (state_i.frame_count == 8'd0) begin
      // lead byte: printable text in print mode, else opcode or drop
      if (state_i.print_mode && lead_op != OP_LOCATE && byte_i >= PRINT_LOW && !byte_i[7]) begin
        state_o.cursor_col  = state_i.cursor_col + 8'd1;
        result_o.show_char  = 1'b1;
        result_o.event_kind = KIND_PRINT;
      end else begin
        state_o.print_mode = 1'b0;
        if ({1'b0, lead_op} < OPCODE_LIMIT) begin
          state_o.current_opcode    = lead_op;
          state_o.send_length       = send_len(lead_op);
          state_o.expected_response = resp_len(lead_op);
          state_o.frame_count       = 8'd1;
          in_frame                  = 1'b1;
        end else begin
          result_o.event_kind = KIND_DROP;
          result_o.opcode     = lead_op;
        end
      end
    end else begin
      // argument byte
      result_o.byte_index = state_i.frame_count;
      if (state_i.frame_count == 8'd1) begin
        arg_one_o = byte_i;
      end else if (state_i.frame_count == 8'd2) begin
        arg_two_o = byte_i;
      end
      state_o.frame_count = count_inc;

      // variable frame ends on a zero byte past its minimum length
      if (state_i.send_length[7] && count_inc > {1'b0, state_i.send_length[6:0]}
          && byte_i == 8'd0) begin
        state_o.send_length = count_inc;
      end

      // second byte may replace the opcode
      if (count_inc == 8'd2) begin
        if (state_i.current_opcode == OP_CLEAR && byte_i == CLEAR_ARG) begin
          result_o.clear_screen     = 1'b1;
          result_o.redirected       = 1'b1;
          state_o.current_opcode    = byte_i[6:0];
          state_o.send_length       = send_len(byte_i[6:0]);
          state_o.expected_response = resp_len(byte_i[6:0]);
          state_o.frame_count       = 8'd1;
        end else if (state_i.current_opcode == OP_REDIRECT && byte_i > REDIRECT_MIN) begin
          result_o.redirected       = 1'b1;
          state_o.current_opcode    = byte_i[6:0];
          state_o.send_length       = send_len(byte_i[6:0]);
          state_o.expected_response = resp_len(byte_i[6:0]);
          state_o.frame_count       = 8'd1;
        end
      end
      in_frame = 1'b1;
    end

    // frame completion and locate handling
    if (in_frame) begin
      result_o.opcode          = state_o.current_opcode;
      result_o.response_length = state_o.expected_response;
      if (state_o.frame_count != 8'd0 && state_o.frame_count == state_o.send_length) begin
        result_o.event_kind = KIND_DONE;
        if (state_o.current_opcode == OP_LOCATE) begin
          state_o.print_mode    = !(state_i.last_locate_x == arg_one_o
                                    && state_i.last_locate_y == arg_two_o);
          state_o.last_locate_x = arg_one_o;
          state_o.last_locate_y = arg_two_o;
          state_o.cursor_col    = arg_one_o;
          state_o.cursor_row    = arg_two_o;
        end
        state_o.frame_count = 8'd0;
      end
    end

    result_o.locate_mode = state_o.print_mode;
    result_o.cursor_x    = state_o.cursor_col;
    result_o.cursor_y    = state_o.cursor_row;
  end

endmodule

@@ src/subcpu_command_framer_top.sv @@
// Command framer for the host to sub-processor byte port. Every accepted byte gives exactly one
// result beat, in order: the byte waits in the input register, then passes through the opcode
// table lookup and frame counter update into the result register. A byte can be accepted in every
// cycle, so the sustained rate is one byte per cycle while the result side takes a beat each cycle;
// the input register takes one more byte while a result waits, and then both registers are full.
module subcpu_command_framer_top
  import cmdfr_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  cmdfr_in_if.sink    in_i,
  cmdfr_out_if.source out_o
);

  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          out_valid_q;
  cmdfr_result_t res_q;
  cmdfr_result_t res_d;
  cmdfr_state_t  state_q;
  cmdfr_state_t  state_d;
  logic [7:0]    arg_one_q;
  logic [7:0]    arg_one_d;
  logic [7:0]    arg_two_q;
  logic [7:0]    arg_two_d;
  logic          advance;
  logic          process;

  // the result register frees up when empty or when its beat is taken
  assign advance    = !out_valid_q || out_o.ready;
  assign process    = advance && in_valid_q;
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
    end
  end

  // framing logic
  cmdfr_decode u_decode (
    .state_i   (state_q),
    .arg_one_i (arg_one_q),
    .arg_two_i (arg_two_q),
    .byte_i    (in_byte_q),
    .state_o   (state_d),
    .arg_one_o (arg_one_d),
    .arg_two_o (arg_two_d),
    .result_o  (res_d)
  );

  // framer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (process) begin
      state_q <= state_d;
    end
  end

  // argument bytes
  always_ff @(posedge clk_i) begin
    if (process) begin
      arg_one_q <= arg_one_d;
      arg_two_q <= arg_two_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.event_kind      = res_q.event_kind;
  assign out_o.byte_value      = res_q.byte_value;
  assign out_o.byte_index      = res_q.byte_index;
  assign out_o.opcode          = res_q.opcode;
  assign out_o.response_length = res_q.response_length;
  assign out_o.redirected      = res_q.redirected;
  assign out_o.clear_screen    = res_q.clear_screen;
  assign out_o.locate_mode     = res_q.locate_mode;
  assign out_o.show_char       = res_q.show_char;
  assign out_o.cursor_x        = res_q.cursor_x;
  assign out_o.cursor_y        = res_q.cursor_y;

endmodule

@@ src/cmdfr_checker.sv @@
module cmdfr_checker
  import cmdfr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] event_kind_i,
  input logic [7:0] byte_value_i,
  input logic [7:0] byte_index_i,
  input logic [6:0] opcode_i,
  input logic [7:0] response_length_i,
  input logic       redirected_i,
  input logic       clear_screen_i,
  input logic       locate_mode_i,
  input logic       show_char_i
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_value_i)
      && $stable(event_kind_i))
    else $error("stalled result beat changed");

  // a printed byte is drawn and leaves print mode on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (show_char_i == (event_kind_i == KIND_PRINT))
      && (!show_char_i || locate_mode_i))
    else $error("print beat inconsistent");

  // a dropped byte is a lead byte past the opcode table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_kind_i == KIND_DROP |->
      {1'b0, opcode_i} >= OPCODE_LIMIT && byte_index_i == 8'd0
      && response_length_i == 8'd0 && !locate_mode_i)
    else $error("dropped byte inconsistent");

  // redirects only happen on the second byte of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (redirected_i || clear_screen_i) |->
      redirected_i && byte_index_i == 8'd1
      && (!clear_screen_i || opcode_i == CLEAR_ARG[6:0]))
    else $error("redirect beat inconsistent");

endmodule

bind subcpu_command_framer_top cmdfr_checker u_cmdfr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .event_kind_i      (out_o.event_kind),
  .byte_value_i      (out_o.byte_value),
  .byte_index_i      (out_o.byte_index),
  .opcode_i          (out_o.opcode),
  .response_length_i (out_o.response_length),
  .redirected_i      (out_o.redirected),
  .clear_screen_i    (out_o.clear_screen),
  .locate_mode_i     (out_o.locate_mode),
  .show_char_i       (out_o.show_char)
);
